// File: hdl/xml_tag_nesting_checker_top_defines.svh
// Assertion macros for the XML tag nesting checker.
`ifndef XML_TAG_NESTING_CHECKER_TOP_DEFINES_SVH
`define XML_TAG_NESTING_CHECKER_TOP_DEFINES_SVH
`ifndef SYNTH
`define XNC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define XNC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define XNC_ASSERT_IMP(lbl, ante, cons)
`define XNC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hdl/xnc_pkg.sv
// Constants, codes and types shared by the XML tag nesting checker.
package xnc_pkg;
  localparam int MAX_DEPTH = 64;
  localparam int MAX_NAME  = 64;
  localparam int DEPTH_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int NAME_W    = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
  localparam int DCNT_W    = $clog2(MAX_DEPTH + 1);
  localparam int LEN_W     = $clog2(MAX_NAME + 1);
  localparam int ON_AW     = DEPTH_W + NAME_W;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [1:0] QC_NONE = 2'd0;
  localparam logic [1:0] QC_EVEN = 2'd1;
  localparam logic [1:0] QC_ODD  = 2'd2;

  typedef struct packed {
    logic                 nb_we;
    logic [NAME_W-1:0]    nb_waddr;
    logic [7:0]           nb_wdata;
    logic [NAME_W-1:0]    nb_raddr;
    logic                 on_we;
    logic [ON_AW-1:0]     on_waddr;
    logic [7:0]           on_wdata;
    logic [ON_AW-1:0]     on_raddr;
    logic                 ol_we;
    logic [DEPTH_W-1:0]   ol_waddr;
    logic [LEN_W-1:0]     ol_wdata;
    logic [DEPTH_W-1:0]   ol_raddr;
  } xnc_mem_req_t;

  typedef struct packed {
    logic [7:0]       nb_rdata;
    logic [7:0]       on_rdata;
    logic [LEN_W-1:0] ol_rdata;
  } xnc_mem_rsp_t;

  function automatic logic is_name_byte(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39) || (c == CH_DASH);
  endfunction
endpackage

// File: hdl/xnc_if.sv
// Handshake channels for document bytes and verdicts.
interface xnc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

interface xnc_out_if;
  logic valid;
  logic ready;
  logic well_formed;
  modport source (output valid, output well_formed, input ready);
  modport sink (input valid, input well_formed, output ready);
endinterface

// File: hdl/xml_tag_nesting_checker_top.sv
// Top level of the XML tag nesting checker: sequencer and name memories.
// Takes one document byte per word and gives one verdict word after the byte marked last.
// Ordinary bytes are taken one per cycle. A '>' stalls input while the sequencer
// walks the open-name memories: it reads the stored length of each open entry,
// compares the name byte by byte where the lengths agree, finds that no entry is
// left when none matched, copies the name byte by byte and writes its length when
// a start tag is pushed, and then finishes the tag. After the last byte the block
// loads the verdict, and it waits there for as long as the previous verdict has
// not been taken. The single read port of each name memory gives every read its
// own step in this walk.
module xml_tag_nesting_checker_top
  import xnc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  xnc_in_if.sink     in_bus,
  xnc_out_if.source  out_bus
);
  xnc_mem_req_t mem_req;
  xnc_mem_rsp_t mem_rsp;

  xnc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .mem_req (mem_req),
    .mem_rsp (mem_rsp)
  );

  // Name being collected in the current tag.
  xnc_ram #(.WIDTH(8), .DEPTH(1 << NAME_W)) u_name_buf (
    .clk   (clk),
    .we    (mem_req.nb_we),
    .waddr (mem_req.nb_waddr),
    .wdata (mem_req.nb_wdata),
    .raddr (mem_req.nb_raddr),
    .rdata (mem_rsp.nb_rdata)
  );

  xnc_ram #(.WIDTH(8), .DEPTH(1 << ON_AW)) u_open_names (
    .clk   (clk),
    .we    (mem_req.on_we),
    .waddr (mem_req.on_waddr),
    .wdata (mem_req.on_wdata),
    .raddr (mem_req.on_raddr),
    .rdata (mem_rsp.on_rdata)
  );

  xnc_ram #(.WIDTH(LEN_W), .DEPTH(1 << DEPTH_W)) u_open_lens (
    .clk   (clk),
    .we    (mem_req.ol_we),
    .waddr (mem_req.ol_waddr),
    .wdata (mem_req.ol_wdata),
    .raddr (mem_req.ol_raddr),
    .rdata (mem_rsp.ol_rdata)
  );
endmodule

// File: hdl/xnc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module xnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/xnc_ctrl.sv
// Byte parser and tag-matching sequencer of the XML tag nesting checker.
`include "xml_tag_nesting_checker_top_defines.svh"
module xnc_ctrl
  import xnc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  xnc_in_if.sink        in_bus,
  xnc_out_if.source     out_bus,
  output xnc_mem_req_t  mem_req,
  input  xnc_mem_rsp_t  mem_rsp
);
  typedef enum logic [3:0] {
    S_IDLE, S_LRD, S_LCHK, S_BRD, S_BCHK, S_CRD, S_CWR, S_PUSH, S_FIN, S_DONE
  } state_t;

  state_t              state_r;
  logic                in_tag_r;
  logic [1:0]          kind_r;
  logic [1:0]          quote_r;
  logic [LEN_W-1:0]    len_r;
  logic [DCNT_W-1:0]   depth_r;
  logic                root_closed_r;
  logic                failed_r;
  logic                last_pend_r;
  logic [DCNT_W-1:0]   j_r;
  logic [DCNT_W-1:0]   hi_r;
  logic [LEN_W-1:0]    k_r;
  logic                out_valid_r;
  logic                wf_r;

  logic accept;
  logic append;
  logic gt_go;
  logic [LEN_W-1:0] k_inc;

  assign in_bus.ready        = (state_r == S_IDLE);
  assign accept              = in_bus.valid && in_bus.ready;
  assign out_bus.valid       = out_valid_r;
  assign out_bus.well_formed = wf_r;
  assign k_inc               = k_r + LEN_W'(1);

  assign append = accept && !failed_r && in_tag_r && is_name_byte(in_bus.ch) &&
                  (quote_r == QC_NONE) && (len_r < LEN_W'(MAX_NAME));
  assign gt_go  = accept && !failed_r && (in_bus.ch == CH_GT) && in_tag_r &&
                  (quote_r != QC_ODD);

  always_comb begin
    mem_req.nb_we    = append;
    mem_req.nb_waddr = len_r[NAME_W-1:0];
    mem_req.nb_wdata = in_bus.ch;
    mem_req.nb_raddr = k_r[NAME_W-1:0];
    mem_req.on_we    = (state_r == S_CWR);
    mem_req.on_waddr = {depth_r[DEPTH_W-1:0], k_r[NAME_W-1:0]};
    mem_req.on_wdata = mem_rsp.nb_rdata;
    mem_req.on_raddr = {j_r[DEPTH_W-1:0], k_r[NAME_W-1:0]};
    mem_req.ol_we    = (state_r == S_PUSH);
    mem_req.ol_waddr = depth_r[DEPTH_W-1:0];
    mem_req.ol_wdata = len_r;
    mem_req.ol_raddr = j_r[DEPTH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      in_tag_r      <= 1'b0;
      kind_r        <= KIND_START;
      quote_r       <= QC_NONE;
      len_r         <= '0;
      depth_r       <= '0;
      root_closed_r <= 1'b0;
      failed_r      <= 1'b0;
      last_pend_r   <= 1'b0;
      j_r           <= '0;
      hi_r          <= '0;
      k_r           <= '0;
      out_valid_r   <= 1'b0;
      wf_r          <= 1'b0;
    end else begin
      // A verdict that is taken while the next one is loaded stays valid.
      if (out_valid_r && out_bus.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            last_pend_r <= in_bus.last;
            if (append) begin
              len_r <= len_r + LEN_W'(1);
            end
            if (!failed_r) begin
              if (in_bus.ch == CH_LT) begin
                if (in_tag_r || root_closed_r) begin
                  failed_r <= 1'b1;
                end else begin
                  in_tag_r <= 1'b1;
                end
              end else if (in_bus.ch == CH_GT) begin
                if (!gt_go) begin
                  failed_r <= 1'b1;
                end
              end else if (in_tag_r) begin
                if (in_bus.ch == CH_SLASH) begin
                  kind_r <= (len_r != '0) ? KIND_EMPTY : KIND_CLOSE;
                end else if (is_name_byte(in_bus.ch) && quote_r == QC_NONE) begin
                  if (!append) begin
                    failed_r <= 1'b1;
                  end
                end else if (in_bus.ch == CH_SPACE) begin
                  quote_r <= QC_EVEN;
                end else if (in_bus.ch == CH_QUOTE && quote_r != QC_NONE) begin
                  quote_r <= (quote_r == QC_EVEN) ? QC_ODD : QC_EVEN;
                end
              end
            end
            if (gt_go) begin
              hi_r <= depth_r;
              j_r  <= '0;
              if (kind_r == KIND_START && depth_r >= DCNT_W'(MAX_DEPTH)) begin
                failed_r <= 1'b1;
                state_r  <= S_FIN;
              end else if (kind_r == KIND_CLOSE) begin
                if (depth_r == '0) begin
                  failed_r <= 1'b1;
                  state_r  <= S_FIN;
                end else begin
                  // A close tag is only checked against the top entry.
                  j_r     <= depth_r - DCNT_W'(1);
                  state_r <= S_LRD;
                end
              end else begin
                state_r <= S_LRD;
              end
            end else if (in_bus.last) begin
              state_r <= S_DONE;
            end
          end
        end
        S_LRD: begin
          if (j_r >= hi_r) begin
            // No open entry matched the collected name.
            k_r <= '0;
            if (kind_r == KIND_START) begin
              state_r <= (len_r == '0) ? S_PUSH : S_CRD;
            end else begin
              if (kind_r == KIND_CLOSE) begin
                failed_r <= 1'b1;
              end
              state_r <= S_FIN;
            end
          end else begin
            state_r <= S_LCHK;
          end
        end
        S_LCHK: begin
          if (mem_rsp.ol_rdata != len_r) begin
            j_r     <= j_r + DCNT_W'(1);
            state_r <= S_LRD;
          end else if (len_r == '0) begin
            if (kind_r == KIND_CLOSE) begin
              depth_r       <= depth_r - DCNT_W'(1);
              root_closed_r <= (depth_r == DCNT_W'(1));
            end else begin
              failed_r <= 1'b1;
            end
            state_r <= S_FIN;
          end else begin
            k_r     <= '0;
            state_r <= S_BRD;
          end
        end
        S_BRD: begin
          state_r <= S_BCHK;
        end
        S_BCHK: begin
          if (mem_rsp.nb_rdata != mem_rsp.on_rdata) begin
            j_r     <= j_r + DCNT_W'(1);
            state_r <= S_LRD;
          end else if (k_inc == len_r) begin
            if (kind_r == KIND_CLOSE) begin
              depth_r       <= depth_r - DCNT_W'(1);
              root_closed_r <= (depth_r == DCNT_W'(1));
            end else begin
              failed_r <= 1'b1;
            end
            state_r <= S_FIN;
          end else begin
            k_r     <= k_inc;
            state_r <= S_BRD;
          end
        end
        S_CRD: begin
          state_r <= S_CWR;
        end
        S_CWR: begin
          k_r     <= k_inc;
          state_r <= (k_inc == len_r) ? S_PUSH : S_CRD;
        end
        S_PUSH: begin
          depth_r <= depth_r + DCNT_W'(1);
          state_r <= S_FIN;
        end
        S_FIN: begin
          in_tag_r <= 1'b0;
          kind_r   <= KIND_START;
          quote_r  <= QC_NONE;
          len_r    <= '0;
          state_r  <= last_pend_r ? S_DONE : S_IDLE;
        end
        S_DONE: begin
          // Waits here while the previous verdict has not been taken.
          if (!out_valid_r || out_bus.ready) begin
            out_valid_r   <= 1'b1;
            wf_r          <= !failed_r && (depth_r == '0) && !in_tag_r;
            in_tag_r      <= 1'b0;
            kind_r        <= KIND_START;
            quote_r       <= QC_NONE;
            len_r         <= '0;
            depth_r       <= '0;
            root_closed_r <= 1'b0;
            failed_r      <= 1'b0;
            last_pend_r   <= 1'b0;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `XNC_ASSERT_IMP(a_busy_not_ready, state_r != S_IDLE, !in_bus.ready)
  `XNC_ASSERT_IMP(a_push_fits, state_r == S_PUSH, depth_r < DCNT_W'(MAX_DEPTH))
  `XNC_ASSERT_IMP(a_copy_in_name, state_r == S_CWR, k_r < len_r)
  `XNC_ASSERT_NXT(a_done_clears, state_r == S_DONE && (!out_valid_r || out_bus.ready), depth_r == '0 && !failed_r && out_valid_r)
endmodule
